// File: hw/rtl/bps_pkg.sv
// Shared types, op codes and rhythm tables for the beep pattern sequencer.
package bps_pkg;

	localparam int unsigned OP_W       = 2;
	localparam int unsigned PAT_W      = 3;
	localparam int unsigned STEP_W     = 3;
	localparam int unsigned MS_W       = 9;

	// Op codes
	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_PLAY = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP = 2'd2;

	// Rhythm numbers
	localparam logic [PAT_W-1:0] PAT_TICK   = 3'd0;
	localparam logic [PAT_W-1:0] PAT_ARRIVE = 3'd1;
	localparam logic [PAT_W-1:0] PAT_PINCH  = 3'd2;
	localparam logic [PAT_W-1:0] PAT_FAULT  = 3'd3;
	localparam logic [PAT_W-1:0] PAT_PAIRED = 3'd4;
	localparam logic [PAT_W-1:0] NUM_PAT    = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [PAT_W-1:0] pattern;
	} in_beat_t;

	typedef struct packed {
		logic buzzer_on;
		logic busy_res;
	} out_beat_t;

	// Duration in ms of one entry of a rhythm; unused entries read zero
	function automatic logic [MS_W-1:0] entry_ms(input logic [PAT_W-1:0] pat,
			input logic [STEP_W-1:0] step);
		logic [MS_W-1:0] ms;
		ms = '0;
		case (pat)
			PAT_TICK: begin
				if (step == 3'd0) ms = 9'd40;
			end
			PAT_ARRIVE: begin
				case (step)
					3'd0: ms = 9'd60;
					3'd1: ms = 9'd80;
					3'd2: ms = 9'd60;
					default: ms = '0;
				endcase
			end
			PAT_PINCH: begin
				case (step)
					3'd0, 3'd2, 3'd4: ms = 9'd80;
					3'd1, 3'd3: ms = 9'd60;
					default: ms = '0;
				endcase
			end
			PAT_FAULT: begin
				case (step)
					3'd0: ms = 9'd400;
					3'd1: ms = 9'd300;
					default: ms = '0;
				endcase
			end
			PAT_PAIRED: begin
				case (step)
					3'd0: ms = 9'd100;
					3'd1: ms = 9'd80;
					3'd2: ms = 9'd200;
					default: ms = '0;
				endcase
			end
			default: ms = '0;
		endcase
		return ms;
	endfunction

	// Number of entries in a rhythm
	function automatic logic [STEP_W-1:0] rhythm_len(input logic [PAT_W-1:0] pat);
		logic [STEP_W-1:0] len;
		case (pat)
			PAT_TICK:   len = 3'd1;
			PAT_ARRIVE: len = 3'd3;
			PAT_PINCH:  len = 3'd5;
			PAT_FAULT:  len = 3'd2;
			PAT_PAIRED: len = 3'd3;
			default:    len = 3'd0;
		endcase
		return len;
	endfunction

endpackage

// File: hw/rtl/beep_pattern_sequencer.sv
// Beep pattern sequencer top level: rhythm state, result register and skid stage.
//
// Usage:
//   The in channel (in_valid/in_ready/in_data) takes one beat per command:
//   a one millisecond tick, a play of rhythm 0..4, or a stop. Every accepted
//   beat yields exactly one beat on the out channel (out_valid/out_ready/
//   out_data) carrying the buzzer level and the busy flag after that command.
//   Throughput: one beat per cycle while the skid register is empty, set by the
//   combinational next-state logic that updates the rhythm registers at
//   acceptance.
//   When the receiver stalls, a second result is caught in a skid register;
//   in_ready drops only while that skid register is full, and results leave
//   strictly in order.
//   Reset (arst_n low) idles the sequencer: buzzer off, not busy, no result
//   pending.
module beep_pattern_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bps_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bps_pkg::out_beat_t out_data
);

	logic                       playing_q;
	logic [bps_pkg::PAT_W-1:0]  pat_q;
	logic [bps_pkg::STEP_W-1:0] step_q;
	logic [bps_pkg::MS_W-1:0]   ms_q;
	logic                       level_q;

	logic                       playing_d;
	logic [bps_pkg::PAT_W-1:0]  pat_d;
	logic [bps_pkg::STEP_W-1:0] step_d;
	logic [bps_pkg::MS_W-1:0]   ms_d;
	logic                       level_d;

	logic [bps_pkg::MS_W-1:0]   ms_dec;
	logic [bps_pkg::STEP_W-1:0] step_nx;
	logic [bps_pkg::STEP_W-1:0] step_new;

	logic                       out_valid_q;
	bps_pkg::out_beat_t         out_q;
	logic                       skid_valid_q;
	bps_pkg::out_beat_t         skid_q;
	bps_pkg::out_beat_t         res;

	logic in_fire;
	logic main_free;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign main_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Compute next rhythm state from the command
	always_comb begin
		playing_d = playing_q;
		pat_d     = pat_q;
		step_d    = step_q;
		ms_d      = ms_q;
		level_d   = level_q;
		ms_dec    = (ms_q != '0) ? ms_q - 1'b1 : ms_q;
		step_nx   = step_q + 1'b1;
		step_new  = '0;
		case (in_data.op)
			bps_pkg::OP_PLAY: begin
				if (in_data.pattern < bps_pkg::NUM_PAT) begin
					pat_d     = in_data.pattern;
					step_d    = '0;
					playing_d = 1'b1;
					ms_d      = bps_pkg::entry_ms(in_data.pattern, '0);
					level_d   = 1'b1;
				end
			end
			bps_pkg::OP_STOP: begin
				playing_d = 1'b0;
				level_d   = 1'b0;
				step_d    = '0;
				ms_d      = '0;
			end
			bps_pkg::OP_TICK: begin
				if (playing_q && pat_q < bps_pkg::NUM_PAT) begin
					ms_d = ms_dec;
					if (ms_dec == '0) begin
						if (step_nx >= bps_pkg::rhythm_len(pat_q)) begin
							step_d = '0;
							if (pat_q == bps_pkg::PAT_FAULT) begin
								ms_d    = bps_pkg::entry_ms(pat_q, '0);
								level_d = 1'b1;
							end else begin
								playing_d = 1'b0;
								level_d   = 1'b0;
							end
						end else begin
							step_new = step_nx;
							step_d   = step_new;
							ms_d     = bps_pkg::entry_ms(pat_q, step_new);
							level_d  = !step_new[0];
						end
					end
				end
			end
			default: begin
			end
		endcase
		res.buzzer_on = level_d;
		res.busy_res  = playing_d;
	end

	// Advance rhythm state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			pat_q     <= '0;
			step_q    <= '0;
			ms_q      <= '0;
			level_q   <= 1'b0;
		end else if (in_fire) begin
			playing_q <= playing_d;
			pat_q     <= pat_d;
			step_q    <= step_d;
			ms_q      <= ms_d;
			level_q   <= level_d;
		end
	end

	// Hold results in the output register, spill to skid when stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Move payloads alongside the valid flags
	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res;
			end
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

endmodule

// File: hw/rtl/bps_checker.sv
// Port-level checker for the beep pattern sequencer, bound to the top level.
module bps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input bps_pkg::in_beat_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input bps_pkg::out_beat_t out_data
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out beat dropped while stalled");

	// Drop ready only while a result is pending
	a_ready_backed: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no result pending");

	// Sound the buzzer only while busy
	a_level_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.buzzer_on |-> out_data.busy_res)
		else $error("buzzer on while idle");

	// Stop into an empty output shows silence next cycle
	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && in_data.op == bps_pkg::OP_STOP
		|=> out_valid && !out_data.busy_res && !out_data.buzzer_on)
		else $error("stop did not silence the buzzer");

	// Valid play into an empty output sounds next cycle
	a_play_sound: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && in_data.op == bps_pkg::OP_PLAY
		&& in_data.pattern < bps_pkg::NUM_PAT
		|=> out_valid && out_data.busy_res && out_data.buzzer_on)
		else $error("play did not start the buzzer");

endmodule

bind beep_pattern_sequencer bps_checker u_bps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
